// ===== hw/rtl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 byte encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_LONE_SURR = 2'd1,
		STATUS_NUL       = 2'd2
	} status_t;

	localparam int unsigned UNIT_W = 16;
	localparam int unsigned CP_W   = 21;

	localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hd800;
	localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hdbff;
	localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hdc00;
	localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hdfff;

	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
	localparam logic [CP_W-1:0] MAX_1B    = 21'h7f;
	localparam logic [CP_W-1:0] MAX_2B    = 21'h7ff;
	localparam logic [CP_W-1:0] MAX_3B    = 21'hffff;

	localparam logic [7:0] LEAD_2B = 8'hc0;
	localparam logic [7:0] LEAD_3B = 8'he0;
	localparam logic [7:0] LEAD_4B = 8'hf0;
	localparam logic [7:0] CONT_B  = 8'h80;

	// bytes in emission order, byte 0 first; last_idx is count minus one
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} utf8_seq_t;

	function automatic utf8_seq_t encode_cp(input logic [CP_W-1:0] cp);
		utf8_seq_t s;
		s.bytes = '0;
		if (cp <= MAX_1B) begin
			s.bytes[0] = cp[7:0];
			s.last_idx = 2'd0;
		end else if (cp <= MAX_2B) begin
			s.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
			s.bytes[1] = CONT_B | {2'b00, cp[5:0]};
			s.last_idx = 2'd1;
		end else if (cp <= MAX_3B) begin
			s.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
			s.bytes[1] = CONT_B | {2'b00, cp[11:6]};
			s.bytes[2] = CONT_B | {2'b00, cp[5:0]};
			s.last_idx = 2'd2;
		end else begin
			s.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
			s.bytes[1] = CONT_B | {2'b00, cp[17:12]};
			s.bytes[2] = CONT_B | {2'b00, cp[11:6]};
			s.bytes[3] = CONT_B | {2'b00, cp[5:0]};
			s.last_idx = 2'd3;
		end
		return s;
	endfunction

endpackage

// ===== hw/rtl/utf16_to_utf8_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte per
// result, with error results for lone surrogates and NUL units.
// ----------------------------------------------------------------------------
// One code unit is taken per request into an input register, where it is
// decoded against the held surrogate state; its 1 to 4 UTF-8 bytes, or a
// single zero byte for an error, are loaded into a result buffer once it is
// free, and the buffer hands out one byte per cycle while out_ready is high.
// A unit that gives no result (a held high surrogate, or a unit dropped after
// an error) passes without waiting on the result buffer. The output port is
// the limit: a unit takes as many output transfers as it has result bytes, so
// 1 to 3 for a plain unit and 4 for the low half of a surrogate pair, with a
// new unit accepted in the same cycle the previous unit's last byte is taken.
module utf16_to_utf8_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  utf8_byte,
	output logic [1:0]  status,
	output logic        last_of_item,
	output logic        closes_string
);

	// input register
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        end_s1;

	// surrogate and string state
	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       string_failed_q;

	// result buffer
	logic                  valid_s2;
	logic [3:0][7:0]       bytes_s2;
	logic [1:0]            last_idx_s2;
	logic [1:0]            idx_s2;
	u16u8_pkg::status_t    status_s2;
	logic                  end_s2;

	// decode
	logic                  is_high;
	logic                  is_low;
	logic                  emit;
	logic                  err;
	u16u8_pkg::status_t    err_status;
	logic [20:0]           cp;
	u16u8_pkg::utf8_seq_t  seq;
	logic                  nxt_pending;
	logic [9:0]            nxt_high_bits;
	logic                  nxt_failed;
	logic                  buf_free;
	logic                  adv_s1;
	logic                  out_last;

	assign is_high = (unit_s1 >= u16u8_pkg::HIGH_FIRST) && (unit_s1 <= u16u8_pkg::HIGH_LAST);
	assign is_low  = (unit_s1 >= u16u8_pkg::LOW_FIRST) && (unit_s1 <= u16u8_pkg::LOW_LAST);

	// pair: 0x10000 + (high << 10) + low offset
	assign cp = high_pending_q
		? (u16u8_pkg::SUPP_BASE + {1'b0, high_bits_q, unit_s1[9:0]})
		: {5'd0, unit_s1};
	assign seq = u16u8_pkg::encode_cp(cp);

	always_comb begin
		emit          = 1'b0;
		err           = 1'b0;
		err_status    = u16u8_pkg::STATUS_OK;
		nxt_pending   = high_pending_q;
		nxt_high_bits = high_bits_q;
		nxt_failed    = string_failed_q;
		if (string_failed_q) begin
			if (end_s1) begin
				nxt_failed    = 1'b0;
				nxt_pending   = 1'b0;
				nxt_high_bits = '0;
			end
		end else if (high_pending_q) begin
			nxt_pending   = 1'b0;
			nxt_high_bits = '0;
			if (!is_low) begin
				err        = 1'b1;
				err_status = u16u8_pkg::STATUS_LONE_SURR;
			end else begin
				emit = 1'b1;
			end
		end else if (is_high) begin
			if (end_s1) begin
				err        = 1'b1;
				err_status = u16u8_pkg::STATUS_LONE_SURR;
			end else begin
				nxt_pending   = 1'b1;
				nxt_high_bits = unit_s1[9:0];
			end
		end else if (is_low) begin
			err        = 1'b1;
			err_status = u16u8_pkg::STATUS_LONE_SURR;
		end else if (unit_s1 == '0) begin
			err        = 1'b1;
			err_status = u16u8_pkg::STATUS_NUL;
		end else begin
			emit = 1'b1;
		end
		if (err) begin
			nxt_pending   = 1'b0;
			nxt_high_bits = '0;
			nxt_failed    = !end_s1;
		end
	end

	assign out_last = (idx_s2 == last_idx_s2);
	assign buf_free = !valid_s2 || (out_ready && out_last);
	// units with no result never wait on the buffer
	assign adv_s1   = valid_s1 && (buf_free || !(emit || err));
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s1 <= code_unit;
			end_s1  <= string_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q  <= 1'b0;
			high_bits_q     <= '0;
			string_failed_q <= 1'b0;
		end else if (adv_s1) begin
			high_pending_q  <= nxt_pending;
			high_bits_q     <= nxt_high_bits;
			string_failed_q <= nxt_failed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (buf_free) begin
			valid_s2 <= adv_s1 && (emit || err);
			idx_s2   <= '0;
		end else if (out_ready) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_free && adv_s1 && (emit || err)) begin
			if (err) begin
				bytes_s2    <= '0;
				last_idx_s2 <= '0;
				status_s2   <= err_status;
				end_s2      <= 1'b1;
			end else begin
				bytes_s2    <= seq.bytes;
				last_idx_s2 <= seq.last_idx;
				status_s2   <= u16u8_pkg::STATUS_OK;
				end_s2      <= end_s1;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign utf8_byte     = bytes_s2[idx_s2];
	assign status        = status_s2;
	assign last_of_item  = out_last;
	assign closes_string = out_last && end_s2;

`ifndef SYNTHESIS
	// an error result is always a single closing result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != u16u8_pkg::STATUS_OK)) |->
		(last_of_item && closes_string && (utf8_byte == 8'd0)))
		else $error("error result is not a single closing zero byte");

	// byte index never passes the last byte of the item
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 <= last_idx_s2))
		else $error("result byte index out of range");

	// an error clears any held surrogate
	assert property (@(posedge clk) disable iff (!arst_n)
		string_failed_q |-> !high_pending_q)
		else $error("surrogate held in a failed string");

	// a taken non-final byte is followed by the next byte of the same item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_item) |=>
		(out_valid && (idx_s2 == $past(idx_s2) + 2'd1)))
		else $error("multi-byte result sequence broken");

	// every byte after the first of an item is a continuation byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (idx_s2 != 2'd0)) |-> (utf8_byte[7:6] == 2'b10))
		else $error("continuation byte malformed");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf16_to_utf8_transcoder_core. Directed code units
// cover the encoding boundaries, surrogate pairs and every error path, then
// random strings (mostly well formed, some noise) run with random idling on
// both handshakes. Every byte is compared with a behavioral UTF-8 encoder.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ITEM_COUNT     = 270;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] code_unit;
	logic        string_end;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  utf8_byte;
	logic [1:0]  status;
	logic        last_of_item;
	logic        closes_string;

	class utf8_scoreboard;
		typedef struct packed {
			logic [7:0]          byte_val;
			u16u8_pkg::status_t  st;
			logic                last;
			logic                closes;
		} utf8_result_t;

		utf8_result_t expected_q[$];
		bit           high_held;
		logic [9:0]   high_bits;
		bit           dropping;
		int           mismatches;
		int           requests_seen;
		int           bytes_checked;
		int           pairs_seen;
		int           errors_seen;

		function int outstanding();
			return expected_q.size();
		endfunction

		function void push_error(u16u8_pkg::status_t st, logic at_end);
			utf8_result_t r;
			r = '{8'h00, st, 1'b1, 1'b1};
			expected_q = {expected_q, r};
			high_held = 0;
			high_bits = '0;
			dropping = !at_end;
			errors_seen++;
		endfunction

		function void push_code_point(logic [20:0] cp, logic at_end);
			logic [7:0]   seq [4];
			int           n;
			utf8_result_t r;
			if (cp < 21'h80) begin
				seq[0] = cp[7:0];
				n = 1;
			end else if (cp < 21'h800) begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
				n = 2;
			end else if (cp < 21'h10000) begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
				n = 3;
			end else begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
				n = 4;
			end
			for (int k = 0; k < n; k++) begin
				r = '{seq[k], u16u8_pkg::STATUS_OK, k == n - 1, (k == n - 1) && at_end};
				expected_q = {expected_q, r};
			end
		endfunction

		function void note_request(logic [15:0] unit, logic at_end);
			bit          is_high;
			bit          is_low;
			logic [20:0] cp;
			is_high = unit >= u16u8_pkg::HIGH_FIRST && unit <= u16u8_pkg::HIGH_LAST;
			is_low = unit >= u16u8_pkg::LOW_FIRST && unit <= u16u8_pkg::LOW_LAST;
			requests_seen++;
			// rest of a failed string is swallowed up to its end flag
			if (dropping) begin
				if (at_end) begin
					dropping = 0;
					high_held = 0;
					high_bits = '0;
				end
				return;
			end
			if (high_held) begin
				if (!is_low) begin
					push_error(u16u8_pkg::STATUS_LONE_SURR, at_end);
					return;
				end
				cp = 21'h10000 + {1'b0, high_bits, unit[9:0]};
				high_held = 0;
				high_bits = '0;
				pairs_seen++;
				push_code_point(cp, at_end);
				return;
			end
			if (is_high) begin
				if (at_end)
					push_error(u16u8_pkg::STATUS_LONE_SURR, 1'b1);
				else begin
					high_held = 1;
					high_bits = unit[9:0];
				end
			end else if (is_low)
				push_error(u16u8_pkg::STATUS_LONE_SURR, at_end);
			else if (unit == 16'h0000)
				push_error(u16u8_pkg::STATUS_NUL, at_end);
			else
				push_code_point({5'd0, unit}, at_end);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] b, logic [1:0] st, logic last, logic closes);
			utf8_result_t exp_r;
			if (expected_q.size() == 0) begin
				report($sformatf("byte %02h with no request waiting", b));
				return;
			end
			exp_r = expected_q.pop_front();
			bytes_checked++;
			if (b !== exp_r.byte_val)
				report($sformatf("utf8_byte %02h, expected %02h", b, exp_r.byte_val));
			if (st !== exp_r.st)
				report($sformatf("status %0d, expected %0d", st, exp_r.st));
			if (last !== exp_r.last)
				report($sformatf("last_of_item %0b, expected %0b", last, exp_r.last));
			if (closes !== exp_r.closes)
				report($sformatf("closes_string %0b, expected %0b", closes, exp_r.closes));
		endtask
	endclass

	utf8_scoreboard board;
	bit             calm;
	int             idle_cycles;

	utf16_to_utf8_transcoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.string_end    (string_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.utf8_byte     (utf8_byte),
		.status        (status),
		.last_of_item  (last_of_item),
		.closes_string (closes_string)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_request(code_unit, string_end);
		if (arst_n && out_valid && out_ready)
			board.check_result(utf8_byte, status, last_of_item, closes_string);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL utf16_to_utf8_transcoder_core");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task send_unit(input logic [15:0] unit, input logic at_end);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		string_end <= at_end;
		do @(posedge clk); while (!in_ready);
	endtask

	function logic [15:0] random_plain();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h0001, 16'h007f));
			1: return 16'($urandom_range(16'h0080, 16'h07ff));
			2: return 16'($urandom_range(16'h0800, 16'hd7ff));
			default: return 16'($urandom_range(16'he000, 16'hffff));
		endcase
	endfunction

	function logic [15:0] random_noise();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'($urandom_range(u16u8_pkg::HIGH_FIRST, u16u8_pkg::HIGH_LAST));
			2: return 16'($urandom_range(u16u8_pkg::LOW_FIRST, u16u8_pkg::LOW_LAST));
			default: return 16'($urandom_range(16'h0000, 16'hffff));
		endcase
	endfunction

	task send_clean_string();
		int len;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) == 0) begin
				send_unit(16'($urandom_range(u16u8_pkg::HIGH_FIRST, u16u8_pkg::HIGH_LAST)),
					1'b0);
				send_unit(16'($urandom_range(u16u8_pkg::LOW_FIRST, u16u8_pkg::LOW_LAST)),
					i == len - 1);
			end else
				send_unit(random_plain(), i == len - 1);
		end
	endtask

	task send_noisy_string();
		int len;
		len = $urandom_range(1, 5);
		for (int i = 0; i < len; i++)
			send_unit(random_noise(), (i == len - 1) || ($urandom_range(9) == 0));
	endtask

	initial begin
		int strings;
		board = new();
		calm = 1'b0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_unit <= '0;
		string_end <= 1'b0;
		out_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encoding boundaries, one to three bytes
		send_unit(16'h0041, 1'b0);
		send_unit(16'h007f, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07ff, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hffff, 1'b1);
		send_unit(16'h0001, 1'b1);
		// lowest and highest surrogate pairs
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b1);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hdfff, 1'b0);
		send_unit(16'hd7ff, 1'b0);
		send_unit(16'he000, 1'b1);
		// lone low surrogate, then the string is dropped up to its end
		send_unit(16'hdc00, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hd800, 1'b1);
		// nul at the end of a string does not fail the next one
		send_unit(16'h0000, 1'b1);
		// high surrogate followed by a plain unit
		send_unit(16'hd800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0042, 1'b1);
		// high surrogate carrying the end flag
		send_unit(16'hd800, 1'b1);
		// high followed by high with end flag
		send_unit(16'hd800, 1'b0);
		send_unit(16'hd801, 1'b1);
		send_unit(16'hdfff, 1'b1);
		send_unit(16'h0000, 1'b0);
		send_unit(16'hffff, 1'b1);

		strings = 0;
		while (board.requests_seen < ITEM_COUNT) begin
			calm = strings >= 25 && strings < 40;
			if ($urandom_range(3) != 0)
				send_clean_string();
			else
				send_noisy_string();
			strings++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// let the last accepted request reach the scoreboard
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d code units, %0d random strings", board.requests_seen, strings);
		$display("%0d surrogate pairs, %0d errors, %0d bytes checked, %0d mismatches",
			board.pairs_seen, board.errors_seen, board.bytes_checked, board.mismatches);
		if (board.mismatches == 0)
			$display("PASS utf16_to_utf8_transcoder_core");
		else
			$display("FAIL utf16_to_utf8_transcoder_core");
		$finish;
	end

endmodule
